// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the port-level checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_RESET(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("reset assertion failed");

`endif

// ===== hw/rtl/aoe_pkg.sv =====
// types, constants and helpers for the audio onset envelope block
// no dependencies
`default_nettype none

package aoe_pkg;

   localparam int SAMPLE_BITS      = 24;
   localparam int HOP_COUNT_BITS   = 10;
   localparam int SMOOTH_FRAC_BITS = 8;
   localparam int SQUARE_BITS      = 2 * SAMPLE_BITS;
   localparam int ENERGY_BITS      = 56;
   localparam int RMS_BITS         = 24;
   localparam int LEVEL_BITS       = 32;
   localparam int RSP_DEPTH        = 2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOP_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEREO     = 2'd1;

   localparam logic [HOP_COUNT_BITS-1:0] HOP_LENGTH_RESET = 10'd240;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_left;
      logic signed [SAMPLE_BITS-1:0] sample_right;
      logic                          end_of_stream;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] onset_value;
      logic [RMS_BITS-1:0]   rms_level;
      logic                  last;
   } rsp_type;

   // one finished hop handed from front to back
   typedef struct packed {
      logic [ENERGY_BITS-1:0]    energy_sum;
      logic [HOP_COUNT_BITS-1:0] hop_count;
      logic                      eos;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_SQRT,
      BK_DONE
   } back_state_type;

   function automatic logic [SAMPLE_BITS-1:0] sample_mag(input logic [SAMPLE_BITS-1:0] v);
      logic [SAMPLE_BITS-1:0] neg;
      neg = ~v + 1'b1;
      return v[SAMPLE_BITS-1] ? neg : v;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aoe_queue.sv =====
// small first-in first-out queue of fixed-width words
// no dependencies
`default_nettype none

module aoe_queue #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   input  wire logic                       pop,
   output logic      [WIDTH-1:0]           pop_data,
   output logic                            empty,
   output logic                            full,
   output logic      [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH+1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH-1);

   logic [WIDTH-1:0]    mem [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign count    = count_ff;
   assign pop_data = mem[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/aoe_front.sv =====
// front end: squares samples, averages channels in stereo mode, accumulates hop energy
// depends on aoe_pkg; feeds finished hops into the command queue
`default_nettype none

module aoe_front
   import aoe_pkg::*;
#(
   parameter int CMD_DEPTH = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire req_type                        req_data,
   input  wire logic [HOP_COUNT_BITS-1:0]      hop_length,
   input  wire logic                           stereo,
   input  wire logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count,
   output logic                                cmd_push,
   output cmd_type                             cmd_data
);

   localparam int CNT_BITS = $clog2(CMD_DEPTH+1);

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_eos_ff;
   logic [SQUARE_BITS-1:0]    s1_left_ff, s1_right_ff;
   logic                      s2_valid_ff, s2_valid_in;
   logic                      s2_eos_ff;
   logic [SQUARE_BITS-1:0]    s2_energy_ff, s2_energy_in;
   logic [ENERGY_BITS-1:0]    sum_ff, sum_in, sum_new;
   logic [HOP_COUNT_BITS-1:0] count_ff, count_in, count_new, hop;
   logic [SAMPLE_BITS-1:0]    mag_left, mag_right;
   logic [SQUARE_BITS:0]      pair_sum;
   logic [CNT_BITS:0]         in_flight;
   logic                      accept, hop_done;

   // every request still in the pipe may need a queue slot
   assign in_flight = {1'b0, cmd_count} + (CNT_BITS+1)'(s1_valid_ff)
                    + (CNT_BITS+1)'(s2_valid_ff);
   assign req_full  = (in_flight >= (CNT_BITS+1)'(CMD_DEPTH));
   assign accept    = req_push && !req_full;

   assign mag_left    = sample_mag(req_data.sample_left);
   assign mag_right   = sample_mag(req_data.sample_right);
   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_left_ff  <= mag_left * mag_left;
         s1_right_ff <= mag_right * mag_right;
         s1_eos_ff   <= req_data.end_of_stream;
      end
   end

   // floor of the two-channel mean
   assign pair_sum     = {1'b0, s1_left_ff} + {1'b0, s1_right_ff};
   assign s2_energy_in = stereo ? pair_sum[SQUARE_BITS:1] : s1_left_ff;
   assign s2_valid_in  = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_energy_ff <= s2_energy_in;
         s2_eos_ff    <= s1_eos_ff;
      end
   end

   assign hop       = (hop_length == '0) ? HOP_COUNT_BITS'(1) : hop_length;
   assign sum_new   = sum_ff + ENERGY_BITS'(s2_energy_ff);
   assign count_new = count_ff + 1'b1;
   assign hop_done  = s2_valid_ff && (s2_eos_ff || (count_new >= hop));

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (s2_valid_ff) begin
         if (hop_done) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_new;
            count_in = count_new;
         end
      end
   end

   assign cmd_push            = hop_done;
   assign cmd_data.energy_sum = sum_new;
   assign cmd_data.hop_count  = count_new;
   assign cmd_data.eos        = s2_eos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/aoe_back.sv =====
// back end: mean by restoring division, floor square root, level smoothing
// depends on aoe_pkg; takes hops from the command queue, fills the result queue
`default_nettype none

module aoe_back
   import aoe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_empty,
   input  wire cmd_type cmd_data,
   output logic         cmd_pop,
   input  wire logic    rsp_full,
   output logic         rsp_push,
   output rsp_type      rsp_data
);

   localparam int STEP_BITS = $clog2(ENERGY_BITS);
   localparam int SREM_BITS = RMS_BITS + 2;
   localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(ENERGY_BITS-1);
   localparam logic [STEP_BITS-1:0] SQRT_LAST = STEP_BITS'(RMS_BITS-1);

   back_state_type state_ff, state_in;

   logic [ENERGY_BITS-1:0]    quo_ff, quo_in;
   logic [HOP_COUNT_BITS-1:0] div_ff, div_in;
   logic [HOP_COUNT_BITS-1:0] drem_ff, drem_in;
   logic [SREM_BITS-1:0]      srem_ff, srem_in;
   logic [RMS_BITS-1:0]       root_ff, root_in;
   logic [STEP_BITS-1:0]      step_ff, step_in;
   logic                      eos_ff, eos_in;
   logic [LEVEL_BITS-1:0]     smooth_ff, smooth_in;
   logic                      have_prev_ff, have_prev_in;

   logic                      start;
   logic [HOP_COUNT_BITS:0]   dtrial, ddiv, ddiff;
   logic                      dge;
   logic [SREM_BITS+1:0]      strial, ssub, sdiff;
   logic                      sge;
   logic [LEVEL_BITS-1:0]     fx, onset;
   logic [LEVEL_BITS+1:0]     blend;

   assign start = !cmd_empty && !rsp_full;

   // one quotient bit per cycle
   assign dtrial = {drem_ff, quo_ff[ENERGY_BITS-1]};
   assign ddiv   = {1'b0, div_ff};
   assign dge    = (dtrial >= ddiv);
   assign ddiff  = dtrial - ddiv;

   // one root bit per cycle, radicand read two bits at a time from quo_ff
   assign strial = {srem_ff, quo_ff[2*RMS_BITS-1 -: 2]};
   assign ssub   = {2'b00, root_ff, 2'b01};
   assign sge    = (strial >= ssub);
   assign sdiff  = strial - ssub;

   assign fx    = {root_ff, {SMOOTH_FRAC_BITS{1'b0}}};
   assign blend = {2'b00, smooth_ff} + {1'b0, smooth_ff, 1'b0} + {2'b00, fx};
   assign onset = (have_prev_ff && (fx > smooth_ff)) ? fx - smooth_ff : '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (start) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (step_ff == DIV_LAST) begin
               state_in = BK_SQRT;
            end
         end
         BK_SQRT: begin
            if (step_ff == SQRT_LAST) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            cmd_pop = start;
         end
         BK_DONE: begin
            rsp_push = 1'b1;
         end
         default: begin
            cmd_pop  = 1'b0;
            rsp_push = 1'b0;
         end
      endcase
   end

   assign rsp_data.onset_value = onset;
   assign rsp_data.rms_level   = root_ff;
   assign rsp_data.last        = eos_ff;

   always_comb begin
      quo_in       = quo_ff;
      div_in       = div_ff;
      drem_in      = drem_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      eos_in       = eos_ff;
      smooth_in    = smooth_ff;
      have_prev_in = have_prev_ff;
      case (state_ff)
         BK_IDLE: begin
            if (start) begin
               quo_in  = cmd_data.energy_sum;
               div_in  = cmd_data.hop_count;
               eos_in  = cmd_data.eos;
               drem_in = '0;
               step_in = '0;
            end
         end
         BK_DIV: begin
            quo_in  = {quo_ff[ENERGY_BITS-2:0], dge};
            drem_in = dge ? ddiff[HOP_COUNT_BITS-1:0] : dtrial[HOP_COUNT_BITS-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               step_in = '0;
               srem_in = '0;
               root_in = '0;
            end
         end
         BK_SQRT: begin
            quo_in  = {quo_ff[ENERGY_BITS-3:0], 2'b00};
            srem_in = sge ? sdiff[SREM_BITS-1:0] : strial[SREM_BITS-1:0];
            root_in = {root_ff[RMS_BITS-2:0], sge};
            step_in = step_ff + 1'b1;
         end
         BK_DONE: begin
            if (eos_ff) begin
               smooth_in    = '0;
               have_prev_in = 1'b0;
            end else if (have_prev_ff) begin
               smooth_in = blend[LEVEL_BITS+1:2];
            end else begin
               // first hop of a stream seeds the average
               smooth_in    = fx;
               have_prev_in = 1'b1;
            end
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         step_ff      <= '0;
         smooth_ff    <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         smooth_ff    <= smooth_in;
         have_prev_ff <= have_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      drem_ff <= drem_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      eos_ff  <= eos_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/audio_onset_envelope.sv =====
// Path: a hop's last request passes the 2 front stages, then the back end's start, 56 division
// steps, 24 root steps and the done state that pushes the result into the result queue.
// Throughput: one request per cycle while the command queue has room; the back
// end works on one hop at a time (one quotient bit, then one root bit, each cycle).
// Reset (synchronous): queues, hop accumulator and smoothing state cleared,
// hop_length 240, stereo 1. Depends on aoe_pkg, aoe_queue, aoe_front, aoe_back.
`default_nettype none

module audio_onset_envelope
   import aoe_pkg::*;
#(
   parameter int CMD_DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire req_type                   req_data,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH+1);

   logic [HOP_COUNT_BITS-1:0] hop_length_ff, hop_length_in;
   logic                      stereo_ff, stereo_in;
   logic                      cmd_push, cmd_pop, cmd_empty;
   logic [CMD_CNT_BITS-1:0]   cmd_count;
   cmd_type                   cmd_in_data, cmd_out_data;
   logic                      rsp_push, rsp_full;
   rsp_type                   rsp_in_data;

   assign csr_ready = 1'b1;

   always_comb begin
      hop_length_in = hop_length_ff;
      stereo_in     = stereo_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HOP_LENGTH: hop_length_in = csr_data[HOP_COUNT_BITS-1:0];
            CSR_STEREO:     stereo_in     = csr_data[0];
            default: begin
               hop_length_in = hop_length_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_length_ff <= HOP_LENGTH_RESET;
         stereo_ff     <= 1'b1;
      end else begin
         hop_length_ff <= hop_length_in;
         stereo_ff     <= stereo_in;
      end
   end

   aoe_front #(
      .CMD_DEPTH(CMD_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .hop_length (hop_length_ff),
      .stereo     (stereo_ff),
      .cmd_count  (cmd_count),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_in_data)
   );

   aoe_queue #(
      .DEPTH(CMD_DEPTH),
      .WIDTH($bits(cmd_type))
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty),
      .full      (),
      .count     (cmd_count)
   );

   aoe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in_data)
   );

   aoe_queue #(
      .DEPTH(RSP_DEPTH),
      .WIDTH($bits(rsp_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_data),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .full      (rsp_full),
      .count     ()
   );

endmodule

`default_nettype wire

// ===== hw/rtl/aoe_checker.sv =====
// port-level checks for the audio onset envelope block, bound to the top level
// depends on aoe_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module aoe_checker
   import aoe_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_full,
   input wire logic    rsp_empty,
   input wire logic    rsp_pop,
   input wire rsp_type rsp_data
);

   logic rms_ok, onset_ok, rise_ok;

   assign rms_ok   = (rsp_data.rms_level <= 24'h80_0000);
   assign onset_ok = (rsp_data.onset_value <= 32'h8000_0000);
   assign rise_ok  = ((rsp_data.onset_value >> SMOOTH_FRAC_BITS)
                      <= 32'(rsp_data.rms_level));

   // nothing pending and room for a request right after reset
   `ASSERT_RESET(a_reset_idle, clock, reset |=> rsp_empty && !req_full)

   // a waiting result is not lost or changed until it is popped
   `ASSERT_CLK(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))

   // level and onset never exceed full scale
   `ASSERT_CLK(a_rsp_range, clock, reset, !rsp_empty |-> rms_ok && onset_ok)

   // the rise over the average can never exceed the level itself
   `ASSERT_CLK(a_onset_bound, clock, reset, !rsp_empty |-> rise_ok)

endmodule

bind audio_onset_envelope aoe_checker u_checker (.*);

`default_nettype wire
